// File: design/bitmap_block_allocator_macros.svh
// Assertion macros shared by the checker of the bitmap block allocator.
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

// Check a property on every rising edge, ignoring cycles held in reset.
`define BBA_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define BBA_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

// File: design/bba_pkg.sv
// Shared types and constants of the bitmap block allocator.
`default_nettype none
package bba_pkg;

  localparam int ActW    = 3;
  localparam int IdxW    = 12;
  localparam int SpanW   = 13;
  localparam int StatW   = 2;
  localparam int RunW    = 13;
  localparam int ILimW   = 11;
  localparam int DLimW   = 13;
  localparam int CfgW    = 13;
  localparam int PosW    = 14;  // holds index + span and any limit plus one word

  localparam logic [ILimW-1:0] ILimReset = ILimW'(1024);
  localparam logic [DLimW-1:0] DLimReset = DLimW'(4096);

  localparam logic [ActW-1:0] ACT_ALLOC = 3'd0;
  localparam logic [ActW-1:0] ACT_FREE  = 3'd1;
  localparam logic [ActW-1:0] ACT_SET   = 3'd2;
  localparam logic [ActW-1:0] ACT_CLR   = 3'd3;
  localparam logic [ActW-1:0] ACT_RUN   = 3'd4;

  localparam logic [StatW-1:0] ST_OK     = 2'd0;
  localparam logic [StatW-1:0] ST_NONE   = 2'd1;
  localparam logic [StatW-1:0] ST_RANGE  = 2'd2;

  localparam logic CFG_INODE_LIMIT = 1'b0;
  localparam logic CFG_DATA_LIMIT  = 1'b1;

  typedef struct packed {
    logic clr;   // clearing pass, one word per cycle
    logic load;  // latch a new request
    logic pre;   // check request for an immediate answer
    logic rd;    // read the word under the cursor
    logic proc;  // process the word read
  } bba_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic pre_done;
    logic word_fin;
  } bba_stat_t;

endpackage
`default_nettype wire

// File: design/bba_ctrl.sv
// Controller state machine of the bitmap block allocator.
`default_nettype none
module bba_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  input  bba_pkg::bba_stat_t  stat,
  output bba_pkg::bba_cmd_t   cmd,
  output logic                busy,
  output logic                done
);
  import bba_pkg::*;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_PRE, S_READ, S_PROC} state_t;
  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_PRE;
        end
      end
      S_PRE: begin
        cmd.pre    = 1'b1;
        state_next = stat.pre_done ? S_IDLE : S_READ;
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_PROC;
      end
      S_PROC: begin
        cmd.proc   = 1'b1;
        state_next = stat.word_fin ? S_IDLE : S_READ;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      busy  <= 1'b1;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
      done  <= (state == S_PRE && stat.pre_done) || (state == S_PROC && stat.word_fin);
    end
  end

endmodule
`default_nettype wire

// File: design/bba_dp.sv
// Datapath of the bitmap block allocator: bitmaps, cursor and word logic.
`default_nettype none
module bba_dp #(
  parameter int INODE_CAP  = 1024,
  parameter int DATA_CAP   = 4096,
  parameter int WORD_BITS  = 32
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         cfg_we,
  input  wire                         cfg_index,
  input  wire  [bba_pkg::CfgW-1:0]    cfg_data,
  input  wire  [bba_pkg::ActW-1:0]    action,
  input  wire                         which_map,
  input  wire  [bba_pkg::IdxW-1:0]    index,
  input  wire  [bba_pkg::SpanW-1:0]   span,
  input  bba_pkg::bba_cmd_t           cmd,
  output bba_pkg::bba_stat_t          stat,
  output logic [bba_pkg::StatW-1:0]   status,
  output logic [bba_pkg::IdxW-1:0]    found_index,
  output logic [bba_pkg::RunW-1:0]    run_length
);
  import bba_pkg::*;

  localparam int IWords = (INODE_CAP + WORD_BITS - 1) / WORD_BITS;
  localparam int DWords = (DATA_CAP + WORD_BITS - 1) / WORD_BITS;
  localparam int MaxW   = (IWords > DWords) ? IWords : DWords;
  localparam int IAw    = (IWords > 1) ? $clog2(IWords) : 1;
  localparam int DAw    = (DWords > 1) ? $clog2(DWords) : 1;
  localparam int CAw    = (MaxW > 1) ? $clog2(MaxW) : 1;
  localparam int LW     = $clog2(WORD_BITS);
  localparam logic [PosW-1:0] WordStep = PosW'(WORD_BITS);

  logic [WORD_BITS-1:0] imem [IWords];
  logic [WORD_BITS-1:0] dmem [DWords];
  logic [WORD_BITS-1:0] rd_i, rd_d;

  logic [ILimW-1:0] inode_limit;
  logic [DLimW-1:0] data_limit;
  logic [ActW-1:0]  op;
  logic             ino;
  logic             phase;
  logic [PosW-1:0]  cur, hi, found;
  logic [CAw-1:0]   clr_addr;

  // Request decode at load
  logic [PosW-1:0] lim, idx_w, end_w, hi_load, cur_load;
  always_comb begin
    if (which_map)
      lim = (int'(inode_limit) < INODE_CAP) ? PosW'(inode_limit) : PosW'(INODE_CAP);
    else
      lim = (int'(data_limit) < DATA_CAP) ? PosW'(data_limit) : PosW'(DATA_CAP);
    idx_w    = PosW'(index);
    end_w    = idx_w + PosW'(span);
    cur_load = (action == ACT_ALLOC) ? '0 : idx_w;
    case (action)
      ACT_FREE:         hi_load = (idx_w < lim) ? idx_w + PosW'(1) : '0;
      ACT_SET, ACT_CLR: hi_load = (end_w < lim) ? end_w : lim;
      default:          hi_load = lim;
    endcase
  end

  // Word logic
  logic [PosW-1:0]      base, nxt, hoff_w;
  logic [LW-1:0]        lo_off, pz, po;
  logic [WORD_BITS-1:0] d, m, z, o, hmask, wdata;
  logic                 wr, fin;
  logic [StatW-1:0]     fin_st;
  logic [PosW-1:0]      fin_found, fin_run, cur_next;
  logic                 phase_next;

  always_comb begin
    d      = ino ? rd_i : rd_d;
    base   = {cur[PosW-1:LW], {LW{1'b0}}};
    nxt    = base + WordStep;
    lo_off = cur[LW-1:0];
    hoff_w = hi - base;
    if (hi >= nxt) hmask = '1;
    else hmask = {WORD_BITS{1'b1}} >> (WORD_BITS - int'(hoff_w[LW-1:0]));
    m = ({WORD_BITS{1'b1}} << lo_off) & hmask;
    z = ~d & m;
    o = d & m;
    pz = '0;
    po = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (z[j]) pz = LW'(j);
      if (o[j]) po = LW'(j);
    end
  end

  always_comb begin
    wr         = 1'b0;
    wdata      = d;
    fin        = 1'b0;
    fin_st     = ST_OK;
    fin_found  = '0;
    fin_run    = '0;
    cur_next   = nxt;
    phase_next = phase;
    case (op)
      ACT_ALLOC: begin
        if (|z) begin
          wr        = 1'b1;
          wdata     = d | (WORD_BITS'(1) << pz);
          fin       = 1'b1;
          fin_found = base + PosW'(pz);
        end else if (nxt >= hi) begin
          fin    = 1'b1;
          fin_st = ST_NONE;
        end
      end
      ACT_FREE: begin
        wr    = 1'b1;
        wdata = d & ~m;
        fin   = 1'b1;
      end
      ACT_SET: begin
        wr    = 1'b1;
        wdata = d | m;
        fin   = (nxt >= hi);
      end
      ACT_CLR: begin
        wr    = 1'b1;
        wdata = d & ~m;
        fin   = (nxt >= hi);
      end
      ACT_RUN: begin
        if (!phase) begin
          if (|z) begin
            cur_next   = base + PosW'(pz);
            phase_next = 1'b1;
          end else if (nxt >= hi) begin
            fin    = 1'b1;
            fin_st = ST_NONE;
          end
        end else begin
          fin_found = found;
          if (|o) begin
            fin     = 1'b1;
            fin_run = base + PosW'(po) - found;
          end else if (nxt >= hi) begin
            fin     = 1'b1;
            fin_run = hi - found;
          end
        end
      end
      default: fin = 1'b1;
    endcase
  end

  always_comb begin
    stat.clr_last = (clr_addr == CAw'(MaxW - 1));
    stat.pre_done = (op > ACT_RUN) || (cur >= hi);
    stat.word_fin = fin;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      inode_limit <= ILimReset;
      data_limit  <= DLimReset;
      clr_addr    <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_INODE_LIMIT) inode_limit <= cfg_data[ILimW-1:0];
        else data_limit <= cfg_data[DLimW-1:0];
      end
      if (cmd.clr) clr_addr <= clr_addr + CAw'(1);
    end
  end

  // Request state and results
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= action;
      ino   <= which_map;
      cur   <= cur_load;
      hi    <= hi_load;
      phase <= 1'b0;
    end
    if (cmd.pre && stat.pre_done) begin
      case (op)
        ACT_ALLOC:        status <= ST_NONE;
        ACT_FREE, ACT_RUN: status <= ST_RANGE;
        default:          status <= ST_OK;
      endcase
      found_index <= '0;
      run_length  <= '0;
    end
    if (cmd.proc) begin
      cur   <= cur_next;
      phase <= phase_next;
      if (!phase && phase_next) found <= cur_next;
      if (fin) begin
        status      <= fin_st;
        found_index <= fin_found[IdxW-1:0];
        run_length  <= fin_run[RunW-1:0];
      end
    end
  end

  // Bitmaps: cleared by the sweep after reset, then read-modify-write per word
  logic [PosW-1:0] widx;
  assign widx = cur >> LW;

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      if (int'(clr_addr) < IWords) imem[IAw'(clr_addr)] <= '0;
      if (int'(clr_addr) < DWords) dmem[DAw'(clr_addr)] <= '0;
    end else if (cmd.proc && wr) begin
      if (ino) imem[IAw'(widx)] <= wdata;
      else dmem[DAw'(widx)] <= wdata;
    end
    if (cmd.rd) begin
      rd_i <= imem[IAw'(widx)];
      rd_d <= dmem[DAw'(widx)];
    end
  end

endmodule
`default_nettype wire

// File: design/bitmap_block_allocator.sv
// Top level of the bitmap block allocator.
//
// Two first-fit allocation bitmaps, one for inodes and one for data blocks.
// Usage:
//   - Raise start with action, which_map, index and span; the request word is
//     taken on a rising edge where start is high and busy is low.
//   - One result word follows per request: done is high for exactly one cycle
//     with status, found_index and run_length valid. The receiver cannot stall.
//   - Limits are written through cfg_we / cfg_index / cfg_data while idle;
//     index 0 is inode_limit, index 1 is data_limit.
// Timing:
//   - A request answered without touching memory (out of range, empty range,
//     unknown action) raises done from the early check, with no word loop.
//   - Otherwise each bitmap word visited takes a registered read (S_READ),
//     then a modify and write back (S_PROC); a run search visits its first
//     free word twice. The single-port word read-modify-write loop sets the
//     rate.
// Reset:
//   - rst clears the limits to 1024 (inode) and 4096 (data) and then sweeps
//     both maps to zero, one word per cycle, during which busy stays high.
//     WORD_BITS must be a power of two.
`default_nettype none
module bitmap_block_allocator #(
  parameter int INODE_CAP  = 1024,
  parameter int DATA_CAP   = 4096,
  parameter int WORD_BITS  = 32
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         start,
  output logic                        busy,
  output logic                        done,
  input  wire                         cfg_we,
  input  wire                         cfg_index,
  input  wire  [bba_pkg::CfgW-1:0]    cfg_data,
  input  wire  [bba_pkg::ActW-1:0]    action,
  input  wire                         which_map,
  input  wire  [bba_pkg::IdxW-1:0]    index,
  input  wire  [bba_pkg::SpanW-1:0]   span,
  output logic [bba_pkg::StatW-1:0]   status,
  output logic [bba_pkg::IdxW-1:0]    found_index,
  output logic [bba_pkg::RunW-1:0]    run_length
);
  import bba_pkg::*;

  bba_cmd_t  cmd;
  bba_stat_t stat;

  // Sequence the request: clear sweep, load, early check, word loop
  bba_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Hold the maps, the limits and the result word
  bba_dp #(
    .INODE_CAP  (INODE_CAP),
    .DATA_CAP   (DATA_CAP),
    .WORD_BITS  (WORD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .action      (action),
    .which_map   (which_map),
    .index       (index),
    .span        (span),
    .cmd         (cmd),
    .stat        (stat),
    .status      (status),
    .found_index (found_index),
    .run_length  (run_length)
  );

endmodule
`default_nettype wire

// File: design/bba_checker.sv
// Port-level checker of the bitmap block allocator and its bind.
`default_nettype none
`include "bitmap_block_allocator_macros.svh"
module bba_checker (
  input wire                        clk,
  input wire                        rst,
  input wire                        start,
  input wire                        busy,
  input wire                        done,
  input wire [bba_pkg::StatW-1:0]   status
);
  import bba_pkg::*;

  `BBA_ASSERT(a_done_idle, clk, rst, done |-> !busy, "result word while busy")
  `BBA_ASSERT(a_accept_busy, clk, rst, (start && !busy) |=> busy, "accepted word not held busy")
  `BBA_ASSERT(a_done_pulse, clk, rst, done |=> !done, "result strobe longer than one cycle")
  `BBA_ASSERT(a_status_code, clk, rst, done |-> (status == ST_OK || status == ST_NONE || status == ST_RANGE), "bad status")
  `BBA_ASSERT_ALWAYS(a_reset_busy, clk, rst |=> (busy && !done), "not busy after reset")

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .status (status)
);
`default_nettype wire

// File: tb/sv/bitmap_block_allocator_tb.sv
// Self-checking testbench of the bitmap block allocator: directed and random requests.
`default_nettype none
module bitmap_block_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bba_pkg::*;

  localparam int INODE_SIZE = 1024;
  localparam int DATA_SIZE  = 4096;
  localparam int WATCHDOG_CYCLES = 4000;
  localparam int SETTLE_CYCLES   = 300;

  // Opcodes the package does not name, and the map selector
  localparam logic [ActW-1:0] ACT_UNKNOWN = 3'd7;
  localparam logic [ActW-1:0] ACT_ODD     = 3'd5;
  localparam logic MAP_DATA  = 1'b0;
  localparam logic MAP_INODE = 1'b1;

  typedef struct {
    logic [ActW-1:0]  act;
    logic             map_sel;
    logic [IdxW-1:0]  idx;
    logic [SpanW-1:0] spn;
  } request_t;

  typedef struct {
    logic [StatW-1:0] stat;
    logic [IdxW-1:0]  found;
    logic [RunW-1:0]  run;
  } answer_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy, done;
  logic             cfg_we = 1'b0;
  logic             cfg_index = 1'b0;
  logic [CfgW-1:0]  cfg_data = '0;
  logic [ActW-1:0]  action = '0;
  logic             which_map = 1'b0;
  logic [IdxW-1:0]  index = '0;
  logic [SpanW-1:0] span = '0;
  logic [StatW-1:0] status;
  logic [IdxW-1:0]  found_index;
  logic [RunW-1:0]  run_length;

  request_t pending_requests[$];
  answer_t  expected_answers[$];
  bit       failed = 1'b0;

  // Shadow copy of both bitmaps and the limit registers
  bit              inode_used[INODE_SIZE];
  bit              data_used[DATA_SIZE];
  logic [ILimW-1:0] inode_limit_reg = ILimReset;
  logic [DLimW-1:0] data_limit_reg  = DLimReset;

  bitmap_block_allocator u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .action(action), .which_map(which_map), .index(index), .span(span),
    .status(status), .found_index(found_index), .run_length(run_length)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Effective limit: the register, capped at the size of the map
  function automatic int map_limit(logic map_sel);
    int lim;
    lim = map_sel ? int'(inode_limit_reg) : int'(data_limit_reg);
    if (map_sel && lim > INODE_SIZE) lim = INODE_SIZE;
    if (!map_sel && lim > DATA_SIZE) lim = DATA_SIZE;
    return lim;
  endfunction

  function automatic bit is_used(logic map_sel, int i);
    return map_sel ? inode_used[i] : data_used[i];
  endfunction

  function automatic void mark(logic map_sel, int i, bit v);
    if (map_sel) inode_used[i] = v;
    else data_used[i] = v;
  endfunction

  // Apply one request to the shadow maps and return the answer it must give
  function automatic answer_t allocate_and_answer(request_t r);
    answer_t a;
    int lim, i, stop;
    a.stat = ST_OK;
    a.found = '0;
    a.run = '0;
    lim = map_limit(r.map_sel);
    case (r.act)
      ACT_ALLOC: begin
        a.stat = ST_NONE;
        for (i = 0; i < lim; i++) begin
          if (!is_used(r.map_sel, i)) begin
            mark(r.map_sel, i, 1'b1);
            a.stat = ST_OK;
            a.found = IdxW'(i);
            break;
          end
        end
      end
      ACT_FREE: begin
        if (int'(r.idx) >= lim) a.stat = ST_RANGE;
        else mark(r.map_sel, int'(r.idx), 1'b0);
      end
      ACT_SET, ACT_CLR: begin
        stop = int'(r.idx) + int'(r.spn);
        if (stop > lim) stop = lim;
        for (i = int'(r.idx); i < stop; i++) mark(r.map_sel, i, r.act == ACT_SET);
      end
      ACT_RUN: begin
        if (int'(r.idx) >= lim) begin
          a.stat = ST_RANGE;
        end else begin
          a.stat = ST_NONE;
          i = int'(r.idx);
          while (i < lim && is_used(r.map_sel, i)) i++;
          if (i < lim) begin
            a.stat = ST_OK;
            a.found = IdxW'(i);
            while (i < lim && !is_used(r.map_sel, i)) begin
              a.run = a.run + 1'b1;
              i++;
            end
          end
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  // Sender: bursts of back-to-back words separated by random gaps
  request_t cur_req;
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    logic next_start;
    next_start = start;
    if (!rst) begin
      if (start && !busy) begin
        expected_answers.push_back(allocate_and_answer(cur_req));
        next_start = 1'b0;
      end
      if (!next_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_requests.size() > 0) begin
          cur_req = pending_requests.pop_front();
          action <= cur_req.act;
          which_map <= cur_req.map_sel;
          index <= cur_req.idx;
          span <= cur_req.spn;
          next_start = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 12);
            // leave some long stretches with no gaps at all
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          end
        end
      end
    end
    start <= next_start;
  end

  // Monitor: each done pulse carries one result word, checked against the oldest
  always @(posedge clk) begin
    answer_t exp_a;
    if (!rst && done) begin
      if (expected_answers.size() == 0) begin
        $display("%0t: unexpected result word status=%0d found=%0d run=%0d",
                 $time, status, found_index, run_length);
        failed = 1'b1;
      end else begin
        exp_a = expected_answers.pop_front();
        if (status !== exp_a.stat) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_a.stat, status);
          failed = 1'b1;
        end
        if (found_index !== exp_a.found) begin
          $display("%0t: found_index expected %0d actual %0d",
                   $time, exp_a.found, found_index);
          failed = 1'b1;
        end
        if (run_length !== exp_a.run) begin
          $display("%0t: run_length expected %0d actual %0d",
                   $time, exp_a.run, run_length);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog: count cycles in which no word moves either way
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("%0t: watchdog expired", $time);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic queue_request(logic [ActW-1:0] act, logic map_sel, int idx, int spn);
    request_t r;
    r.act = act;
    r.map_sel = map_sel;
    r.idx = IdxW'(idx);
    r.spn = SpanW'(spn);
    pending_requests.push_back(r);
  endtask

  // Hold until every queued word is answered, then let the block settle
  task automatic wait_idle();
    while (pending_requests.size() > 0 || expected_answers.size() > 0 || start)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(logic reg_idx, int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= reg_idx;
    cfg_data <= CfgW'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (reg_idx == CFG_INODE_LIMIT) inode_limit_reg = ILimW'(value);
    else data_limit_reg = DLimW'(value);
  endtask

  // Random requests: mostly in-range indices and short spans, plus full-width noise
  task automatic queue_random(int count);
    int n, sel, lim, idx, spn;
    logic map_sel;
    logic [ActW-1:0] act;
    for (n = 0; n < count; n++) begin
      map_sel = $urandom_range(0, 1);
      sel = $urandom_range(0, 99);
      if (sel < 30) act = ACT_ALLOC;
      else if (sel < 50) act = ACT_FREE;
      else if (sel < 62) act = ACT_SET;
      else if (sel < 74) act = ACT_CLR;
      else if (sel < 96) act = ACT_RUN;
      else act = ($urandom_range(0, 1) == 0) ? ACT_ODD : ACT_UNKNOWN;
      lim = map_limit(map_sel);
      if (lim > 0 && $urandom_range(0, 9) < 7) idx = $urandom_range(0, lim - 1);
      else idx = $urandom_range(0, 4095);
      if ($urandom_range(0, 4) != 0) spn = $urandom_range(0, 64);
      else spn = $urandom_range(0, 8191);
      queue_request(act, map_sel, idx, spn);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part at reset limits
    queue_request(ACT_ALLOC, MAP_DATA, 0, 0);
    queue_request(ACT_ALLOC, MAP_INODE, 0, 0);
    queue_request(ACT_FREE, MAP_DATA, 0, 0);
    queue_request(ACT_FREE, MAP_INODE, 1024, 0);     // free past the inode limit
    queue_request(ACT_FREE, MAP_DATA, 4095, 0);
    queue_request(ACT_SET, MAP_INODE, 0, 4096);      // fill the whole inode map
    queue_request(ACT_ALLOC, MAP_INODE, 0, 0);       // nothing free
    queue_request(ACT_RUN, MAP_INODE, 0, 0);         // nothing free to report
    queue_request(ACT_CLR, MAP_INODE, 1023, 1);      // lone free last bit
    queue_request(ACT_RUN, MAP_INODE, 5, 0);
    queue_request(ACT_RUN, MAP_INODE, 4095, 0);      // search start out of range
    queue_request(ACT_SET, MAP_DATA, 4000, 8191);    // range clipped at the limit
    queue_request(ACT_CLR, MAP_DATA, 4090, 0);       // empty range
    queue_request(ACT_RUN, MAP_DATA, 0, 0);
    queue_request(ACT_CLR, MAP_DATA, 4064, 32);
    queue_request(ACT_RUN, MAP_DATA, 3999, 0);
    queue_request(ACT_UNKNOWN, MAP_DATA, 4095, 8191);
    queue_request(ACT_ODD, MAP_INODE, 1, 1);
    queue_request(ACT_CLR, MAP_INODE, 0, 8191);
    queue_random(120);
    wait_idle();

    // Both limits at zero: every index is out of range
    write_limit(CFG_INODE_LIMIT, 0);
    write_limit(CFG_DATA_LIMIT, 0);
    queue_random(30);
    wait_idle();

    // Small limits, so maps fill up and allocation runs dry
    write_limit(CFG_INODE_LIMIT, $urandom_range(1, 40));
    write_limit(CFG_DATA_LIMIT, $urandom_range(1, 70));
    queue_random(100);
    wait_idle();

    // Register values above the map size
    write_limit(CFG_INODE_LIMIT, 2047);
    write_limit(CFG_DATA_LIMIT, 8191);
    queue_random(80);
    wait_idle();

    write_limit(CFG_INODE_LIMIT, $urandom_range(100, 1023));
    write_limit(CFG_DATA_LIMIT, $urandom_range(100, 4095));
    queue_random(80);

    while (pending_requests.size() > 0 || expected_answers.size() > 0 || start)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (!failed && expected_answers.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
